[rtl/hsfc_pkg.sv]
// Shared constants and types for the binary32/binary16 format converter.
package hsfc_pkg;

  typedef enum logic {
    CMD_NARROW = 1'b0,
    CMD_WIDEN  = 1'b1
  } cmd_t;

  localparam int unsigned F32_W     = 32;
  localparam int unsigned F32_EXP_W = 8;
  localparam int unsigned F32_MAN_W = 23;
  localparam int unsigned F16_W     = 16;
  localparam int unsigned F16_EXP_W = 5;
  localparam int unsigned F16_MAN_W = 10;

  localparam logic [F32_EXP_W-1:0] F32_BIAS     = 8'd127;
  localparam logic [F32_EXP_W-1:0] F32_EXP_MAX  = 8'hFF;
  localparam logic [F32_EXP_W-1:0] BIAS_DIFF    = 8'd112;
  localparam logic [F16_EXP_W-1:0] F16_EXP_MAX  = 5'h1F;
  localparam logic [F16_W-1:0]     F16_INF      = 16'h7C00;
  localparam logic [F16_W-1:0]     F16_QNAN     = 16'h7E00;

endpackage

[rtl/half_single_float_converter_core.sv]
// Top level of the binary32/binary16 format converter.
// Usage:
//   Input channel in_valid/in_ready carries one beat: in_cmd selects the
//   direction (CMD_NARROW: binary32 to binary16, CMD_WIDEN: binary16 in
//   bits 15..0 to binary32) and in_operand_bits the pattern.
//   Result channel out_valid/out_ready returns one beat per input beat, in
//   order; a binary16 result sits in bits 15..0 with bits 31..16 zero.
// Timing:
//   An accepted beat lands in the operand register, is converted by single
//   pass logic and is captured in the result register, which drives
//   out_valid. One beat per cycle is sustained while out_ready stays high;
//   the operand and result registers form a two-deep pipeline.
// Reset:
//   rst_n low empties both stages; no beat is pending afterwards.
// Stall:
//   While out_ready is low the result holds; the operand stage still takes
//   one more beat, and in_ready drops once both stages are full.
module half_single_float_converter_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [hsfc_pkg::F32_W-1:0] in_operand_bits,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hsfc_pkg::F32_W-1:0] out_result_bits
);
  import hsfc_pkg::*;

  logic               op_valid_r;
  cmd_t               op_cmd_r;
  logic [F32_W-1:0]   op_bits_r;
  logic               res_valid_r;
  logic [F32_W-1:0]   res_bits_r;
  logic [F32_W-1:0]   res_bits_nxt;
  logic               res_ready;
  logic [F16_W-1:0]   narrow_res;
  logic [F32_W-1:0]   widen_res;

  assign res_ready = !res_valid_r || out_ready;
  assign in_ready  = !op_valid_r || res_ready;

  hsfc_narrow u_narrow (
    .operand (op_bits_r),
    .result  (narrow_res)
  );

  hsfc_widen u_widen (
    .operand (op_bits_r[F16_W-1:0]),
    .result  (widen_res)
  );

  always_comb begin
    case (op_cmd_r)
      CMD_NARROW: res_bits_nxt = {16'd0, narrow_res};
      CMD_WIDEN:  res_bits_nxt = widen_res;
      default:    res_bits_nxt = widen_res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        op_valid_r <= in_valid;
      end
      if (res_ready) begin
        res_valid_r <= op_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_cmd_r  <= cmd_t'(in_cmd);
      op_bits_r <= in_operand_bits;
    end
    if (res_ready && op_valid_r) begin
      res_bits_r <= res_bits_nxt;
    end
  end

  assign out_valid       = res_valid_r;
  assign out_result_bits = res_bits_r;

endmodule

[rtl/hsfc_narrow.sv]
// Binary32 to binary16 narrowing with round-to-nearest-even.
module hsfc_narrow (
  input  logic [hsfc_pkg::F32_W-1:0] operand,
  output logic [hsfc_pkg::F16_W-1:0] result
);
  import hsfc_pkg::*;

  logic                  sign;
  logic [F32_EXP_W-1:0]  bexp;
  logic [F32_MAN_W-1:0]  mant;
  logic [F32_EXP_W-1:0]  exp_diff;
  logic [F16_W-2:0]      norm_base;
  logic                  norm_inc;
  logic [F16_W-2:0]      norm_sum;
  logic [F32_EXP_W-1:0]  sub_sh8;
  logic [4:0]            sub_sh;
  logic [47:0]           sub_wide;
  logic [10:0]           sub_kept;
  logic                  sub_inc;
  logic [10:0]           sub_sum;

  assign sign = operand[F32_W-1];
  assign bexp = operand[F32_W-2 -: F32_EXP_W];
  assign mant = operand[F32_MAN_W-1:0];

  // Normal range: exponent and mantissa added as one word so a rounding
  // carry bumps the exponent and saturates to infinity on its own.
  assign exp_diff  = bexp - BIAS_DIFF;
  assign norm_base = {exp_diff[F16_EXP_W-1:0], mant[F32_MAN_W-1 -: F16_MAN_W]};
  assign norm_inc  = mant[12] & ((|mant[11:0]) | mant[13]);
  assign norm_sum  = norm_base + {14'd0, norm_inc};

  // Subnormal range: shift of 14..24 on the mantissa with hidden bit.
  assign sub_sh8  = F32_BIAS - 8'd1 - bexp;
  assign sub_sh   = sub_sh8[4:0];
  assign sub_wide = {1'b1, mant, 24'd0} >> sub_sh;
  assign sub_kept = sub_wide[34:24];
  assign sub_inc  = sub_wide[23] & ((|sub_wide[22:0]) | sub_kept[0]);
  assign sub_sum  = sub_kept + {10'd0, sub_inc};

  always_comb begin
    if (bexp == F32_EXP_MAX) begin
      result = {sign, 15'd0} | F16_INF;
      if (mant != '0) begin
        result = {sign, 15'd0} | F16_QNAN | {6'd0, mant[F32_MAN_W-1 -: F16_MAN_W]};
      end
    end else if (bexp > F32_BIAS + 8'd15) begin
      result = {sign, 15'd0} | F16_INF;
    end else if (bexp >= BIAS_DIFF + 8'd1) begin
      result = {sign, norm_sum};
    end else if (bexp >= F32_BIAS - 8'd25) begin
      result = {sign, 4'd0, sub_sum};
    end else begin
      result = {sign, 15'd0};
    end
  end

endmodule

[rtl/hsfc_widen.sv]
// Binary16 to binary32 widening, exact, with subnormal normalization.
module hsfc_widen (
  input  logic [hsfc_pkg::F16_W-1:0] operand,
  output logic [hsfc_pkg::F32_W-1:0] result
);
  import hsfc_pkg::*;

  logic                  sign;
  logic [F16_EXP_W-1:0]  e;
  logic [F16_MAN_W-1:0]  m;
  logic [3:0]            lz;
  logic [F16_MAN_W-1:0]  m_shift;
  logic [F16_MAN_W-1:0]  sub_frac;
  logic [F32_EXP_W-1:0]  sub_exp;

  assign sign = operand[F16_W-1];
  assign e    = operand[F16_W-2 -: F16_EXP_W];
  assign m    = operand[F16_MAN_W-1:0];

  // Leading-one search: the highest set bit wins.
  always_comb begin
    lz = 4'd0;
    for (int i = 0; i < F16_MAN_W; i++) begin
      if (m[i]) begin
        lz = 4'(F16_MAN_W - 1 - i);
      end
    end
  end

  // Drop the leading one after moving it past the field.
  assign m_shift  = m << lz;
  assign sub_frac = {m_shift[F16_MAN_W-2:0], 1'b0};
  assign sub_exp  = BIAS_DIFF - {4'd0, lz};

  always_comb begin
    if (e == '0) begin
      if (m == '0) begin
        result = {sign, 31'd0};
      end else begin
        result = {sign, sub_exp, sub_frac, 13'd0};
      end
    end else if (e == F16_EXP_MAX) begin
      result = {sign, F32_EXP_MAX, m, 13'd0};
    end else begin
      result = {sign, {3'd0, e} + BIAS_DIFF, m, 13'd0};
    end
  end

endmodule

[verif/tb_half_single_float_converter_core.sv]
// Self-checking testbench for the binary32/binary16 format converter core.
module tb_half_single_float_converter_core;
  import hsfc_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned RANDOM_ITEMS = 1640;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = CMD_NARROW;
  logic [31:0] in_operand_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result_bits;

  logic [31:0] pending_results[$];
  logic [31:0] want_bits;
  int          mismatch_count = 0;
  logic        idle_on = 1'b1;
  logic        hold_tog = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  half_single_float_converter_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_operand_bits (in_operand_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_bits (out_result_bits)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // Round right shift to nearest, ties to even.
  function automatic logic [31:0] round_nearest_even(logic [31:0] value, int unsigned shift);
    logic [31:0] kept;
    logic [31:0] rem;
    logic [31:0] half;
    kept = value >> shift;
    rem  = value & ((32'd1 << shift) - 32'd1);
    half = 32'd1 << (shift - 1);
    if (rem > half || (rem == half && kept[0])) begin
      kept = kept + 32'd1;
    end
    return kept;
  endfunction

  function automatic logic [31:0] narrow_to_half(logic [31:0] v);
    logic [15:0] sgn;
    logic [7:0]  bexp;
    logic [22:0] mant;
    logic [31:0] m;
    logic [4:0]  hexp;
    int          unb;
    sgn  = {v[31], 15'd0};
    bexp = v[30:23];
    mant = v[22:0];
    if (bexp == F32_EXP_MAX) begin
      if (mant != '0) begin
        return {16'd0, sgn | F16_QNAN | {6'd0, mant[22:13]}};
      end
      return {16'd0, sgn | F16_INF};
    end
    unb = int'(bexp) - int'(F32_BIAS);
    if (unb > 15) begin
      return {16'd0, sgn | F16_INF};
    end
    if (unb >= -14) begin
      m = round_nearest_even({9'd0, mant}, 13);
      // carry out of the mantissa bumps the exponent
      if (m > 32'h3FF) begin
        m = '0;
        unb++;
        if (unb > 15) begin
          return {16'd0, sgn | F16_INF};
        end
      end
      hexp = 5'(unb + 15);
      return {16'd0, sgn | {1'b0, hexp, m[9:0]}};
    end
    if (unb >= -25) begin
      m = round_nearest_even({8'd0, 1'b1, mant}, int'(-1 - unb));
      return {16'd0, sgn | m[15:0]};
    end
    return {16'd0, sgn};
  endfunction

  function automatic logic [31:0] widen_to_single(logic [15:0] h);
    logic [4:0]  e;
    logic [10:0] mant;
    int          ex;
    e    = h[14:10];
    mant = {1'b0, h[9:0]};
    if (e == '0) begin
      if (mant == '0) begin
        return {h[15], 31'd0};
      end
      ex = 1;
      // normalize until the hidden bit shows up
      while (!mant[10]) begin
        mant = mant << 1;
        ex--;
      end
      return {h[15], 8'(ex + int'(BIAS_DIFF)), mant[9:0], 13'd0};
    end
    if (e == F16_EXP_MAX) begin
      return {h[15], F32_EXP_MAX, h[9:0], 13'd0};
    end
    return {h[15], 8'(int'(e) + int'(BIAS_DIFF)), h[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] convert_operand(cmd_t c, logic [31:0] v);
    if (c == CMD_WIDEN) begin
      return widen_to_single(v[15:0]);
    end
    return narrow_to_half(v);
  endfunction

  function automatic logic [31:0] pick_single_operand();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(9))
      0, 1: ;
      2, 3, 4, 5, 6: v[30:23] = 8'($urandom_range(143, 101));
      7: v[30:23] = $urandom_range(1) ? F32_EXP_MAX : 8'h00;
      8: begin
        v[30:23] = 8'($urandom_range(143, 110));
        case ($urandom_range(3))
          0: v[12:0] = 13'h1000;
          1: v[12:0] = 13'h0FFF;
          2: v[12:0] = 13'h1001;
          default: v[12:0] = 13'h1FFF;
        endcase
      end
      default: begin
        // subnormal range with cleared low bits to hit exact ties
        v[30:23] = 8'($urandom_range(112, 100));
        v[22:0]  = v[22:0] & (23'h7FFFFF << $urandom_range(22));
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_half_operand();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(3))
      0: v[14:10] = '0;
      1: v[14:10] = F16_EXP_MAX;
      default: ;
    endcase
    return v;
  endfunction

  // Receiver: random idling, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on) begin
      out_ready <= ($urandom_range(99) >= 24);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare result beats first, then record the prediction for an accepted beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result_bits: expected none, actual %h", out_result_bits);
          mismatch_count++;
        end else begin
          want_bits = pending_results.pop_front();
          if (out_result_bits !== want_bits) begin
            $error("result_bits: expected %h, actual %h", want_bits, out_result_bits);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(convert_operand(cmd_t'(in_cmd), in_operand_bits));
      end
    end
  end

  task automatic send_beat(cmd_t c, logic [31:0] v);
    while (idle_on && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= c;
    in_operand_bits <= v;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_narrow_directed();
    logic [31:0] pats[$] = '{
      32'h00000000, 32'h80000000, 32'h007FFFFF, 32'h3F800000, 32'h477FE000,
      32'h477FF000, 32'hFF7FFFFF, 32'h7F800000, 32'hFF800000, 32'h7FC00001,
      32'h7F800001, 32'hFFFFFFFF, 32'h38800000, 32'h387FFFFF, 32'h33800000,
      32'h33000001, 32'hB3000000, 32'h32FFFFFF, 32'h3F801000, 32'h3F803000
    };
    foreach (pats[i]) begin
      send_beat(CMD_NARROW, pats[i]);
    end
  endtask

  task automatic test_widen_directed();
    logic [31:0] pats[$] = '{
      32'h00000000, 32'h00008000, 32'h00000001, 32'h000003FF, 32'h00000400,
      32'h00007BFF, 32'h00007C00, 32'h0000FC00, 32'h00007E00, 32'h00007C01,
      32'hFFFFFFFF, 32'hDEAD3C00
    };
    foreach (pats[i]) begin
      send_beat(CMD_WIDEN, pats[i]);
    end
  endtask

  task automatic send_random_beat();
    if ($urandom_range(1)) begin
      send_beat(CMD_WIDEN, pick_half_operand());
    end else begin
      send_beat(CMD_NARROW, pick_single_operand());
    end
  endtask

  task automatic test_full_rate_stretch();
    idle_on <= 1'b0;
    repeat (200) begin
      send_random_beat();
    end
    idle_on <= 1'b1;
  endtask

  task automatic test_output_hold();
    // Keep offering beats while the receiver holds off, so the pipe fills.
    hold_tog <= ~hold_tog;
    repeat (16) begin
      send_random_beat();
    end
    wait_all_results();
  endtask

  task automatic test_pause_until_empty();
    repeat (20) begin
      send_random_beat();
    end
    wait_all_results();
    repeat (20) begin
      send_random_beat();
    end
    wait_all_results();
  endtask

  task automatic test_random_stream();
    repeat (RANDOM_ITEMS) begin
      send_random_beat();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_narrow_directed();
    test_widen_directed();
    test_full_rate_stretch();
    test_output_hold();
    test_pause_until_empty();
    test_random_stream();

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("result_bits: %0d expected beats never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[half_single_float_converter_core.f]
rtl/hsfc_pkg.sv
rtl/hsfc_narrow.sv
rtl/hsfc_widen.sv
rtl/half_single_float_converter_core.sv
verif/tb_half_single_float_converter_core.sv
